// File: rtl/core/ddmc_pkg.sv
// Shared types, constants and helpers for the differential-drive motor controller.
// Used by ddmc_div and differential_drive_motor_controller; depends on nothing.
package ddmc_pkg;

    // Field and state widths
    localparam int REQ_W      = 2;
    localparam int CODE_W     = 3;
    localparam int DUR_W      = 24;
    localparam int DIR_W      = 4;
    localparam int CMP_W      = 16;
    localparam int CNT_W      = 16;
    localparam int DIST_W     = 34;
    localparam int SPEED_W    = 8;
    localparam int BASE_W     = 16;
    localparam int QDUTY_W    = 18;   // Q2.16 duty
    localparam int OP_W       = 20;   // duty operand, wide enough for the brake duty
    localparam int PERIOD_W   = 16;
    localparam int MUL_A_W    = OP_W + SPEED_W;
    localparam int MUL_B_W    = PERIOD_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int DIVD_W     = 2 * CNT_W;
    localparam int CMP_SHIFT  = 23;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Defaults and fixed values
    localparam int                PWM_PERIOD = 4096;
    localparam logic [SPEED_W-1:0] SPEED_RST = 8'd128;
    localparam logic [BASE_W-1:0]  BASE_RST  = 16'd6554;
    localparam logic [OP_W-1:0]    BRAKE_DUTY = 20'd655360;   // 10.0 in Q.16
    localparam logic [QDUTY_W-1:0] DUTY_MAX  = 18'h3FFFF;
    localparam logic [CNT_W-1:0]   CNT_MAX   = 16'hFFFF;

    // Direction line patterns
    localparam logic [DIR_W-1:0] DIR_OFF   = 4'd0;
    localparam logic [DIR_W-1:0] DIR_FWD   = 4'd5;
    localparam logic [DIR_W-1:0] DIR_BWD   = 4'd10;
    localparam logic [DIR_W-1:0] DIR_ROT_R = 4'd6;
    localparam logic [DIR_W-1:0] DIR_ROT_L = 4'd9;

    typedef enum logic [REQ_W-1:0] {
        REQ_LEFT  = 2'd0,
        REQ_RIGHT = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_CMD   = 2'd3
    } t_req;

    typedef enum logic [CODE_W-1:0] {
        CMD_STOP  = 3'd0,
        CMD_FWD   = 3'd1,
        CMD_BWD   = 3'd2,
        CMD_ROT_R = 3'd3,
        CMD_ROT_L = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_MULT = 1'b0,
        REG_BASE_DUTY  = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_CMP_L1,
        S_CMP_L2,
        S_CMP_R1,
        S_CMP_R2,
        S_CMP_FIN,
        S_OUT
    } t_state;

    // Result sequence: one result, brake+idle, or brake+idle+idle
    typedef enum logic [1:0] {
        SEQ_ONE,
        SEQ_STOP2,
        SEQ_STOP3
    } t_seq;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CODE_W-1:0] cmd_code;
        logic [DUR_W-1:0]  duration;
    } t_in_item;

    typedef struct packed {
        logic [DIR_W-1:0] dir_bits;
        logic [CMP_W-1:0] left_compare;
        logic [CMP_W-1:0] right_compare;
        logic             cmd_ok;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [QDUTY_W-1:0] quotient;
    } t_div_rsp;

    // period * duty * speed >> 23, saturated to 16 bits
    function automatic logic [CMP_W-1:0] sat_compare(input logic [PROD_W-1:0] p);
        logic [CMP_W-1:0] v;
        if (|p[PROD_W-1:CMP_SHIFT+CMP_W]) begin
            v = '1;
        end else begin
            v = p[CMP_SHIFT+CMP_W-1:CMP_SHIFT];
        end
        return v;
    endfunction

endpackage

// File: rtl/core/ddmc_div.sv
// Serial restoring divider for the right-wheel duty, saturating at the Q2.16 maximum.
// Depends on ddmc_pkg for widths and the request/response structs.
module ddmc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ddmc_pkg::t_div_req i_req,
    output ddmc_pkg::t_div_rsp o_rsp
);

    localparam int QW    = ddmc_pkg::QDUTY_W;
    localparam int NW    = ddmc_pkg::CNT_W;
    localparam int DW    = ddmc_pkg::DIVD_W;
    localparam int CTR_W = $clog2(QW + 1);

    logic [NW-1:0]    r_rem;
    logic [QW-1:0]    r_quo;      // remaining dividend bits on top, quotient bits shift in below
    logic [NW-1:0]    r_dvs;
    logic [CTR_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [NW:0]      trial;
    logic             ge;
    logic [NW:0]      diff;
    logic             ovf;

    // One quotient bit per step
    assign trial = {r_rem, r_quo[QW-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    // Quotient would not fit in 18 bits
    assign ovf = {{(NW + QW - DW){1'b0}}, i_req.dividend} >= {i_req.divisor, {QW{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_dvs <= i_req.divisor;
                if (ovf) begin
                    r_quo  <= ddmc_pkg::DUTY_MAX;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_rem  <= {{(NW + QW - DW){1'b0}}, i_req.dividend[DW-1:QW]};
                    r_quo  <= i_req.dividend[QW-1:0];
                    r_cnt  <= CTR_W'(QW);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? diff[NW-1:0] : trial[NW-1:0];
                r_quo <= {r_quo[QW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CTR_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: rtl/core/differential_drive_motor_controller.sv
// Differential-drive motor controller: encoder counting, command handling, regulation.
// Depends on ddmc_pkg and ddmc_div.
//
// Encoder pulse items are accepted while idle and give no result. A command item
// gives one result, computed with two passes through the shared multiplier per
// wheel, a step to load the result, then the output state, held while
// i_out_stall is high; stop and unknown codes give two results. A regulation
// tick takes a multiply step, a divider start step and a divider wait (18
// quotient bits, one per cycle, then the done flag; done follows the start
// directly when the quotient saturates), then the result steps: one result for
// a normal tick, three when it ends the drive. o_in_stall stays high from
// acceptance until the last result of the item is taken. Configuration writes
// are always ready and take effect on the next result computed.
module differential_drive_motor_controller #(
    parameter int P_PWM_PERIOD = ddmc_pkg::PWM_PERIOD
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ddmc_pkg::t_in_item                  i_in_item,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ddmc_pkg::t_out_item                 o_out_item,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ddmc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ddmc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [ddmc_pkg::PERIOD_W-1:0] PERIOD = ddmc_pkg::PERIOD_W'(P_PWM_PERIOD);

    // State
    ddmc_pkg::t_state                r_state, n_state;
    ddmc_pkg::t_seq                  r_seq, n_seq;
    logic [1:0]                      r_idx, n_idx;
    logic                            r_ok, n_ok;
    logic [ddmc_pkg::DIR_W-1:0]      r_dir, n_dir;
    logic [ddmc_pkg::DIST_W-1:0]     r_dist, n_dist;
    logic [ddmc_pkg::QDUTY_W-1:0]    r_left_duty, n_left_duty;
    logic [ddmc_pkg::QDUTY_W-1:0]    r_right_duty, n_right_duty;
    logic [ddmc_pkg::CNT_W-1:0]      r_left_cnt, n_left_cnt;
    logic [ddmc_pkg::CNT_W-1:0]      r_right_cnt, n_right_cnt;
    logic [ddmc_pkg::SPEED_W-1:0]    r_speed, n_speed;
    logic [ddmc_pkg::BASE_W-1:0]     r_base, n_base;
    logic [ddmc_pkg::CMP_W-1:0]      r_lcmp, n_lcmp;
    logic                            r_out_valid, n_out_valid;
    ddmc_pkg::t_out_item             r_out_item, n_out_item;
    logic [ddmc_pkg::PROD_W-1:0]     r_prod;

    // Shared multiplier operands
    logic [ddmc_pkg::MUL_A_W-1:0]    mul_a;
    logic [ddmc_pkg::MUL_B_W-1:0]    mul_b;

    ddmc_pkg::t_div_req              div_req;
    ddmc_pkg::t_div_rsp              div_rsp;

    logic                            in_acc;
    logic                            brake;
    logic [ddmc_pkg::OP_W-1:0]       left_op;
    logic [ddmc_pkg::OP_W-1:0]       right_op;
    logic [1:0]                      last_idx;
    logic [ddmc_pkg::CNT_W:0]        cnt_sum;
    logic [ddmc_pkg::DIST_W-1:0]     dist_after;
    logic                            dist_pos;
    logic [ddmc_pkg::DIST_W-1:0]     dur_fb;
    logic [ddmc_pkg::DIST_W-1:0]     dur_turn;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ddmc_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Brake duty on the first result of a stop sequence
    assign brake    = (r_seq != ddmc_pkg::SEQ_ONE) && (r_idx == 2'd0);
    assign left_op  = brake ? ddmc_pkg::BRAKE_DUTY : {2'b00, r_left_duty};
    assign right_op = brake ? ddmc_pkg::BRAKE_DUTY : {2'b00, r_right_duty};

    always_comb begin
        case (r_seq)
            ddmc_pkg::SEQ_STOP2: last_idx = 2'd1;
            ddmc_pkg::SEQ_STOP3: last_idx = 2'd2;
            default:             last_idx = 2'd0;
        endcase
    end

    // Budget loads and tick update
    assign dur_fb     = {{(ddmc_pkg::DIST_W - ddmc_pkg::DUR_W - 8){1'b0}},
                         i_in_item.duration, 8'h00};
    assign dur_turn   = {{(ddmc_pkg::DIST_W - ddmc_pkg::DUR_W - 4){1'b0}},
                         i_in_item.duration, 4'h0}
                        - {{(ddmc_pkg::DIST_W - ddmc_pkg::DUR_W){1'b0}}, i_in_item.duration};
    assign cnt_sum    = {1'b0, r_left_cnt} + {1'b0, r_right_cnt};
    assign dist_after = r_dist
                        - {{(ddmc_pkg::DIST_W - ddmc_pkg::CNT_W){1'b0}},
                           cnt_sum[ddmc_pkg::CNT_W:1]};
    assign dist_pos   = !dist_after[ddmc_pkg::DIST_W-1] && (|dist_after);

    // Divider request: base * left count over right count (zero reads as one)
    assign div_req.start    = (r_state == ddmc_pkg::S_DIV_GO);
    assign div_req.dividend = r_prod[ddmc_pkg::DIVD_W-1:0];
    assign div_req.divisor  = (r_right_cnt == '0) ? ddmc_pkg::CNT_W'(1) : r_right_cnt;

    ddmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequencer: next state, state updates and multiplier operands
    always_comb begin
        n_state      = r_state;
        n_seq        = r_seq;
        n_idx        = r_idx;
        n_ok         = r_ok;
        n_dir        = r_dir;
        n_dist       = r_dist;
        n_left_duty  = r_left_duty;
        n_right_duty = r_right_duty;
        n_left_cnt   = r_left_cnt;
        n_right_cnt  = r_right_cnt;
        n_speed      = r_speed;
        n_base       = r_base;
        n_lcmp       = r_lcmp;
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;
        mul_a        = '0;
        mul_b        = '0;

        // configuration writes
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (ddmc_pkg::t_reg'(i_cfg_index))
                ddmc_pkg::REG_SPEED_MULT: n_speed = i_cfg_data[ddmc_pkg::SPEED_W-1:0];
                ddmc_pkg::REG_BASE_DUTY:  n_base  = i_cfg_data[ddmc_pkg::BASE_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            ddmc_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_idx = 2'd0;
                    unique case (ddmc_pkg::t_req'(i_in_item.req_type))
                        ddmc_pkg::REQ_LEFT: begin
                            if (r_left_cnt != ddmc_pkg::CNT_MAX) begin
                                n_left_cnt = r_left_cnt + 1'b1;
                            end
                        end
                        ddmc_pkg::REQ_RIGHT: begin
                            if (r_right_cnt != ddmc_pkg::CNT_MAX) begin
                                n_right_cnt = r_right_cnt + 1'b1;
                            end
                        end
                        ddmc_pkg::REQ_TICK: begin
                            n_state = ddmc_pkg::S_TICK_MUL;
                        end
                        default: begin
                            n_state = ddmc_pkg::S_CMP_L1;
                            n_seq   = ddmc_pkg::SEQ_ONE;
                            n_ok    = 1'b1;
                            unique case (ddmc_pkg::t_cmd'(i_in_item.cmd_code))
                                ddmc_pkg::CMD_FWD: begin
                                    n_dist = dur_fb;
                                    n_dir  = ddmc_pkg::DIR_FWD;
                                end
                                ddmc_pkg::CMD_BWD: begin
                                    n_dist = dur_fb;
                                    n_dir  = ddmc_pkg::DIR_BWD;
                                end
                                ddmc_pkg::CMD_ROT_R: begin
                                    n_dist = dur_turn;
                                    n_dir  = ddmc_pkg::DIR_ROT_R;
                                end
                                ddmc_pkg::CMD_ROT_L: begin
                                    n_dist = dur_turn;
                                    n_dir  = ddmc_pkg::DIR_ROT_L;
                                end
                                default: begin
                                    // stop or unknown code: brake then idle
                                    n_seq        = ddmc_pkg::SEQ_STOP2;
                                    n_ok         = (ddmc_pkg::t_cmd'(i_in_item.cmd_code)
                                                    == ddmc_pkg::CMD_STOP);
                                    n_dist       = '0;
                                    n_dir        = ddmc_pkg::DIR_OFF;
                                    n_left_duty  = {2'b00, r_base};
                                    n_right_duty = {2'b00, r_base};
                                end
                            endcase
                        end
                    endcase
                end
            end
            ddmc_pkg::S_TICK_MUL: begin
                mul_a   = {{(ddmc_pkg::MUL_A_W - ddmc_pkg::BASE_W){1'b0}}, r_base};
                mul_b   = r_left_cnt;
                n_state = ddmc_pkg::S_DIV_GO;
            end
            ddmc_pkg::S_DIV_GO: begin
                n_state = ddmc_pkg::S_DIV_WAIT;
            end
            ddmc_pkg::S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_left_cnt  = ddmc_pkg::CNT_W'(1);
                    n_right_cnt = ddmc_pkg::CNT_W'(1);
                    n_ok        = 1'b1;
                    n_state     = ddmc_pkg::S_CMP_L1;
                    if (dist_pos) begin
                        n_seq        = ddmc_pkg::SEQ_ONE;
                        n_dist       = dist_after;
                        n_left_duty  = {2'b00, r_base};
                        n_right_duty = div_rsp.quotient;
                    end else begin
                        // budget used up: brake, idle, idle
                        n_seq        = ddmc_pkg::SEQ_STOP3;
                        n_dist       = '0;
                        n_dir        = ddmc_pkg::DIR_OFF;
                        n_left_duty  = {2'b00, r_base};
                        n_right_duty = {2'b00, r_base};
                    end
                end
            end
            ddmc_pkg::S_CMP_L1: begin
                mul_a   = {{ddmc_pkg::SPEED_W{1'b0}}, left_op};
                mul_b   = {{(ddmc_pkg::MUL_B_W - ddmc_pkg::SPEED_W){1'b0}}, r_speed};
                n_state = ddmc_pkg::S_CMP_L2;
            end
            ddmc_pkg::S_CMP_L2: begin
                mul_a   = r_prod[ddmc_pkg::MUL_A_W-1:0];
                mul_b   = PERIOD;
                n_state = ddmc_pkg::S_CMP_R1;
            end
            ddmc_pkg::S_CMP_R1: begin
                n_lcmp  = ddmc_pkg::sat_compare(r_prod);
                mul_a   = {{ddmc_pkg::SPEED_W{1'b0}}, right_op};
                mul_b   = {{(ddmc_pkg::MUL_B_W - ddmc_pkg::SPEED_W){1'b0}}, r_speed};
                n_state = ddmc_pkg::S_CMP_R2;
            end
            ddmc_pkg::S_CMP_R2: begin
                mul_a   = r_prod[ddmc_pkg::MUL_A_W-1:0];
                mul_b   = PERIOD;
                n_state = ddmc_pkg::S_CMP_FIN;
            end
            ddmc_pkg::S_CMP_FIN: begin
                n_out_valid              = 1'b1;
                n_out_item.dir_bits      = r_dir;
                n_out_item.left_compare  = r_lcmp;
                n_out_item.right_compare = ddmc_pkg::sat_compare(r_prod);
                n_out_item.cmd_ok        = r_ok;
                n_out_item.last          = (r_idx == last_idx);
                n_state                  = ddmc_pkg::S_OUT;
            end
            ddmc_pkg::S_OUT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_idx == last_idx) begin
                        n_state = ddmc_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ddmc_pkg::S_CMP_L1;
                    end
                end
            end
            default: n_state = ddmc_pkg::S_IDLE;
        endcase
    end

    // Shared multiplier, registered
    always_ff @(posedge i_clk) begin
        r_prod <= {{ddmc_pkg::MUL_B_W{1'b0}}, mul_a} * {{ddmc_pkg::MUL_A_W{1'b0}}, mul_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ddmc_pkg::S_IDLE;
            r_seq        <= ddmc_pkg::SEQ_ONE;
            r_idx        <= 2'd0;
            r_ok         <= 1'b1;
            r_dir        <= ddmc_pkg::DIR_OFF;
            r_dist       <= '0;
            r_left_duty  <= {2'b00, ddmc_pkg::BASE_RST};
            r_right_duty <= {2'b00, ddmc_pkg::BASE_RST};
            r_left_cnt   <= '0;
            r_right_cnt  <= '0;
            r_speed      <= ddmc_pkg::SPEED_RST;
            r_base       <= ddmc_pkg::BASE_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_seq        <= n_seq;
            r_idx        <= n_idx;
            r_ok         <= n_ok;
            r_dir        <= n_dir;
            r_dist       <= n_dist;
            r_left_duty  <= n_left_duty;
            r_right_duty <= n_right_duty;
            r_left_cnt   <= n_left_cnt;
            r_right_cnt  <= n_right_cnt;
            r_speed      <= n_speed;
            r_base       <= n_base;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload and left compare hold, no reset
    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        r_lcmp     <= n_lcmp;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef ASSERT_OFF
    // A result is only shown while the sequencer waits on the output
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == ddmc_pkg::S_OUT)
        else $error("result valid outside output state");

    // The final result of an item returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_item.last) |=> r_state == ddmc_pkg::S_IDLE)
        else $error("block not idle after last result");

    // Result index never runs past the sequence length
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ddmc_pkg::S_IDLE |-> r_idx <= last_idx)
        else $error("result index out of range");

    // Divider completes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == ddmc_pkg::S_DIV_WAIT)
        else $error("divider done outside wait state");

    // A brake result always has the direction lines off
    a_brake_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && brake) |-> o_out_item.dir_bits == ddmc_pkg::DIR_OFF)
        else $error("brake result with direction lines on");
`endif

endmodule

// File: verif/tb_differential_drive_motor_controller.sv
`timescale 1ns / 1ps
// Self-checking testbench for differential_drive_motor_controller: drives command, pulse
// and tick items, predicts every result and compares. Depends on ddmc_pkg and the RTL.
module tb_differential_drive_motor_controller;

    localparam int CLK_PERIOD     = 10;
    localparam int RST_CYCLES     = 6;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    // Command codes the block treats as unknown
    localparam logic [ddmc_pkg::CODE_W-1:0] CMD_BAD_FIRST = 3'd5;
    localparam logic [ddmc_pkg::CODE_W-1:0] CMD_BAD_LAST  = 3'd7;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // DUT ports
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_stall;
    ddmc_pkg::t_in_item              i_in_item   = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    ddmc_pkg::t_out_item             o_out_item;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [ddmc_pkg::CFG_IDX_W-1:0]  i_cfg_index = ddmc_pkg::REG_SPEED_MULT;
    logic [ddmc_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    differential_drive_motor_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predicted controller state, starting at reset values
    logic [ddmc_pkg::SPEED_W-1:0]       cfg_speed  = ddmc_pkg::SPEED_RST;
    logic [ddmc_pkg::BASE_W-1:0]        cfg_base   = ddmc_pkg::BASE_RST;
    logic [ddmc_pkg::CNT_W-1:0]         left_cnt   = '0;
    logic [ddmc_pkg::CNT_W-1:0]         right_cnt  = '0;
    logic signed [ddmc_pkg::DIST_W-1:0] budget     = '0;
    logic [ddmc_pkg::QDUTY_W-1:0]       left_duty  = ddmc_pkg::QDUTY_W'(ddmc_pkg::BASE_RST);
    logic [ddmc_pkg::QDUTY_W-1:0]       right_duty = ddmc_pkg::QDUTY_W'(ddmc_pkg::BASE_RST);
    logic [ddmc_pkg::DIR_W-1:0]         dir_lines  = ddmc_pkg::DIR_OFF;

    ddmc_pkg::t_out_item pwm_expect_q[$];
    int unsigned mismatches    = 0;
    int unsigned items_sent    = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // period * duty * speed / 2^23, saturated to 16 bits
    function automatic logic [ddmc_pkg::CMP_W-1:0] pwm_compare(
            input logic [ddmc_pkg::OP_W-1:0] duty);
        logic [63:0] scaled;
        scaled = (64'(ddmc_pkg::PWM_PERIOD) * 64'(duty) * 64'(cfg_speed))
                 >> ddmc_pkg::CMP_SHIFT;
        return (scaled > 64'(ddmc_pkg::CNT_MAX)) ? ddmc_pkg::CNT_MAX
                                                 : scaled[ddmc_pkg::CMP_W-1:0];
    endfunction

    task automatic push_result(input logic [ddmc_pkg::OP_W-1:0] ld,
                               input logic [ddmc_pkg::OP_W-1:0] rd,
                               input logic ok, input logic fin);
        ddmc_pkg::t_out_item r;
        r.dir_bits      = dir_lines;
        r.left_compare  = pwm_compare(ld);
        r.right_compare = pwm_compare(rd);
        r.cmd_ok        = ok;
        r.last          = fin;
        pwm_expect_q.push_back(r);
    endtask

    // Brake result, then idle result at base duty
    task automatic brake_and_idle(input logic ok, input logic idle_last);
        budget    = '0;
        dir_lines = ddmc_pkg::DIR_OFF;
        push_result(ddmc_pkg::BRAKE_DUTY, ddmc_pkg::BRAKE_DUTY, ok, 1'b0);
        left_duty  = ddmc_pkg::QDUTY_W'(cfg_base);
        right_duty = left_duty;
        push_result(left_duty, right_duty, ok, idle_last);
    endtask

    task automatic motor_predict(input ddmc_pkg::t_in_item it);
        logic [2*ddmc_pkg::CNT_W-1:0] num;
        logic [2*ddmc_pkg::CNT_W-1:0] quo;
        logic [ddmc_pkg::CNT_W:0]     mean;
        case (ddmc_pkg::t_req'(it.req_type))
            ddmc_pkg::REQ_LEFT: begin
                if (left_cnt != ddmc_pkg::CNT_MAX) left_cnt = left_cnt + 1'b1;
            end
            ddmc_pkg::REQ_RIGHT: begin
                if (right_cnt != ddmc_pkg::CNT_MAX) right_cnt = right_cnt + 1'b1;
            end
            ddmc_pkg::REQ_CMD: begin
                case (it.cmd_code)
                    ddmc_pkg::CMD_FWD: begin
                        budget    = {2'b00, it.duration, 8'h00};
                        dir_lines = ddmc_pkg::DIR_FWD;
                    end
                    ddmc_pkg::CMD_BWD: begin
                        budget    = {2'b00, it.duration, 8'h00};
                        dir_lines = ddmc_pkg::DIR_BWD;
                    end
                    ddmc_pkg::CMD_ROT_R: begin
                        budget    = ddmc_pkg::DIST_W'(it.duration) * 15;
                        dir_lines = ddmc_pkg::DIR_ROT_R;
                    end
                    ddmc_pkg::CMD_ROT_L: begin
                        budget    = ddmc_pkg::DIST_W'(it.duration) * 15;
                        dir_lines = ddmc_pkg::DIR_ROT_L;
                    end
                    default: brake_and_idle(it.cmd_code == ddmc_pkg::CMD_STOP, 1'b1);
                endcase
                // drive commands leave the lines on and give one result
                if (dir_lines != ddmc_pkg::DIR_OFF) begin
                    push_result(left_duty, right_duty, 1'b1, 1'b1);
                end
            end
            default: begin
                // regulation tick; a zero right count divides by one
                num  = 32'(cfg_base) * 32'(left_cnt);
                quo  = num / ((right_cnt == '0) ? 32'd1 : 32'(right_cnt));
                mean = (17'(left_cnt) + 17'(right_cnt)) >> 1;
                left_duty  = ddmc_pkg::QDUTY_W'(cfg_base);
                right_duty = (quo > 32'(ddmc_pkg::DUTY_MAX)) ? ddmc_pkg::DUTY_MAX
                                                             : quo[ddmc_pkg::QDUTY_W-1:0];
                budget     = budget - ddmc_pkg::DIST_W'(mean);
                left_cnt   = 1;
                right_cnt  = 1;
                if (budget > 0) begin
                    push_result(left_duty, right_duty, 1'b1, 1'b1);
                end else begin
                    brake_and_idle(1'b1, 1'b0);
                    push_result(left_duty, right_duty, 1'b1, 1'b1);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------

    function automatic ddmc_pkg::t_in_item mk_item(input ddmc_pkg::t_req rt,
                                                   input logic [ddmc_pkg::CODE_W-1:0] code,
                                                   input logic [ddmc_pkg::DUR_W-1:0] dur);
        ddmc_pkg::t_in_item it;
        it.req_type = rt;
        it.cmd_code = code;
        it.duration = dur;
        return it;
    endfunction

    // Send one item; valid stays high on return so items can go back to back
    task automatic drive_item(input ddmc_pkg::t_in_item it);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        motor_predict(it);
        items_sent++;
    endtask

    task automatic pulse_burst(input ddmc_pkg::t_req side, input int unsigned n);
        repeat (n) begin
            drive_item(mk_item(side, ddmc_pkg::CODE_W'($urandom),
                               ddmc_pkg::DUR_W'($urandom)));
        end
    endtask

    task automatic send_tick();
        drive_item(mk_item(ddmc_pkg::REQ_TICK, ddmc_pkg::CODE_W'($urandom),
                           ddmc_pkg::DUR_W'($urandom)));
    endtask

    task automatic send_cmd(input logic [ddmc_pkg::CODE_W-1:0] code,
                            input logic [ddmc_pkg::DUR_W-1:0] dur);
        drive_item(mk_item(ddmc_pkg::REQ_CMD, code, dur));
    endtask

    // Drop valid, let every expected result arrive, then give the block time to go idle
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pwm_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers; only called with the block idle
    task automatic set_regs(input logic [ddmc_pkg::SPEED_W-1:0] speed,
                            input logic [ddmc_pkg::BASE_W-1:0] base);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ddmc_pkg::REG_SPEED_MULT;
        i_cfg_data  <= {8'($urandom), speed};
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        cfg_speed = speed;
        i_cfg_index <= ddmc_pkg::REG_BASE_DUTY;
        i_cfg_data  <= base;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        cfg_base = base;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver stalls at random
    always @(posedge i_clk) i_out_stall <= ($urandom_range(99) < recv_idle_pct);

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string fname, input logic [ddmc_pkg::CMP_W-1:0] want_v,
                               input logic [ddmc_pkg::CMP_W-1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, fname, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        ddmc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pwm_expect_q.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, o_out_item);
                mismatches++;
            end else begin
                want = pwm_expect_q.pop_front();
                check_field("dir_bits", want.dir_bits, o_out_item.dir_bits);
                check_field("left_compare", want.left_compare, o_out_item.left_compare);
                check_field("right_compare", want.right_compare, o_out_item.right_compare);
                check_field("cmd_ok", want.cmd_ok, o_out_item.cmd_ok);
                check_field("last", want.last, o_out_item.last);
            end
        end
    end

    // Watchdog: ends the run if no handshake completes for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // First tick after reset: right count is zero, budget is zero -> brake, idle, idle
    task automatic test_first_tick();
        pulse_burst(ddmc_pkg::REQ_LEFT, 1);
        send_tick();
    endtask

    // Every command code, duration extremes, brake compare saturating
    task automatic test_command_codes();
        settle_block();
        set_regs('1, '1);
        send_cmd(ddmc_pkg::CMD_FWD, '0);
        send_cmd(ddmc_pkg::CMD_FWD, '1);
        send_cmd(ddmc_pkg::CMD_BWD, ddmc_pkg::DUR_W'($urandom));
        send_cmd(ddmc_pkg::CMD_ROT_R, '1);
        send_cmd(ddmc_pkg::CMD_ROT_L, ddmc_pkg::DUR_W'($urandom));
        send_cmd(ddmc_pkg::CMD_STOP, ddmc_pkg::DUR_W'($urandom));
        for (int c = CMD_BAD_FIRST; c <= CMD_BAD_LAST; c++) begin
            send_cmd(ddmc_pkg::CODE_W'(c), ddmc_pkg::DUR_W'($urandom));
        end
    endtask

    // Left count far above right count with a large base: right duty saturates
    task automatic test_right_duty_saturation();
        settle_block();
        set_regs(8'd200, '1);
        send_cmd(ddmc_pkg::CMD_ROT_R, 24'd1);
        pulse_burst(ddmc_pkg::REQ_LEFT, 6);
        send_tick();
        send_cmd(ddmc_pkg::CMD_STOP, '0);
    endtask

    // Mostly well-formed drives (command, pulses, ticks) plus random noise
    task automatic test_random_drives(input int unsigned s_pct, input int unsigned r_pct,
                                      input int unsigned n_items);
        int unsigned                  goal;
        int unsigned                  rounds;
        logic [ddmc_pkg::CODE_W-1:0]  code;
        logic [ddmc_pkg::DUR_W-1:0]   dur;
        logic [ddmc_pkg::SPEED_W-1:0] speed;
        logic [ddmc_pkg::BASE_W-1:0]  base;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            // new register values now and then, with the block idle
            if ($urandom_range(3) == 0) begin
                settle_block();
                case ($urandom_range(2))
                    0:       speed = '0;
                    1:       speed = '1;
                    default: speed = ddmc_pkg::SPEED_W'($urandom);
                endcase
                case ($urandom_range(2))
                    0:       base = '0;
                    1:       base = '1;
                    default: base = ddmc_pkg::BASE_W'($urandom);
                endcase
                set_regs(speed, base);
            end
            if ($urandom_range(99) < 20) begin
                // noise: arbitrary items
                repeat ($urandom_range(1, 3)) begin
                    drive_item(mk_item(ddmc_pkg::t_req'($urandom_range(3)),
                                       ddmc_pkg::CODE_W'($urandom),
                                       ddmc_pkg::DUR_W'($urandom)));
                end
            end else begin
                code = ddmc_pkg::CODE_W'($urandom_range(ddmc_pkg::CMD_ROT_L, ddmc_pkg::CMD_FWD));
                if ($urandom_range(7) == 0) begin
                    dur = ddmc_pkg::DUR_W'($urandom);
                end else if (code == ddmc_pkg::CMD_FWD || code == ddmc_pkg::CMD_BWD) begin
                    dur = ddmc_pkg::DUR_W'($urandom_range(1));
                end else begin
                    dur = ddmc_pkg::DUR_W'($urandom_range(2));
                end
                send_cmd(code, dur);
                rounds = $urandom_range(1, 6);
                for (int r = 0; r < rounds && dir_lines != ddmc_pkg::DIR_OFF; r++) begin
                    pulse_burst(ddmc_pkg::REQ_LEFT, $urandom_range(6));
                    pulse_burst(ddmc_pkg::REQ_RIGHT, $urandom_range(6));
                    send_tick();
                end
                // sometimes end the drive by command instead
                if (dir_lines != ddmc_pkg::DIR_OFF && $urandom_range(2) == 0) begin
                    code = $urandom_range(1) ? ddmc_pkg::CMD_STOP
                           : ddmc_pkg::CODE_W'($urandom_range(CMD_BAD_LAST, CMD_BAD_FIRST));
                    send_cmd(code, ddmc_pkg::DUR_W'($urandom));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        send_idle_pct = 20;
        recv_idle_pct = 59;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_first_tick();
        test_command_codes();
        test_right_duty_saturation();
        test_random_drives(20, 59, 20);
        test_random_drives(59, 20, 20);
        test_random_drives(0, 0, 20);

        settle_block();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pwm_expect_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
